// ===== hw/rtl/lgs_pkg.sv =====
// Shared types, constants and helper functions for the baseline grid snapper.
// No dependencies; used by line_grid_snap and lgs_check.
package lgs_pkg;

    localparam int DIM_W   = 31;            // width of a dimension field
    localparam int NUM_W   = 33;            // divider dividend / quotient width
    localparam int DVS_W   = 32;            // divider divisor width
    localparam int WIDE_W  = 38;            // post-divide arithmetic width
    localparam int ADDR_W  = 5;             // APB address width
    localparam int DATA_W  = 32;            // APB data width
    localparam int IN_W    = 64;            // input tdata width
    localparam int OUT_W   = 128;           // output tdata width

    localparam logic signed [DIM_W-1:0] DIM_LIMIT = 31'sd1073741823;

    localparam logic [2:0] REG_SNAP_EN  = 3'd0;
    localparam logic [2:0] REG_LINE_HT  = 3'd1;
    localparam logic [2:0] REG_LINE_DP  = 3'd2;
    localparam logic [2:0] REG_HT_TOL   = 3'd3;
    localparam logic [2:0] REG_DP_TOL   = 3'd4;
    localparam logic [2:0] REG_COM_TOL  = 3'd5;
    localparam logic [2:0] REG_STEP     = 3'd6;
    localparam logic [2:0] REG_PIN      = 3'd7;

    localparam logic [1:0] STEP_WHOLE = 2'd1;
    localparam logic [1:0] STEP_HALF  = 2'd2;

    typedef struct packed {
        logic [DVS_W-1:0] rem;
        logic [NUM_W-1:0] nsh;
        logic [NUM_W-1:0] quo;
    } t_div;

    // One restoring division step: brings in the next dividend bit.
    function automatic t_div div_step(t_div a, logic [DVS_W-1:0] dvs);
        t_div       r;
        logic [DVS_W:0] t;
        t     = {a.rem, a.nsh[NUM_W-1]};
        r.nsh = {a.nsh[NUM_W-2:0], 1'b0};
        if (t >= {1'b0, dvs}) begin
            t     = t - {1'b0, dvs};
            r.quo = {a.quo[NUM_W-2:0], 1'b1};
        end else begin
            r.quo = {a.quo[NUM_W-2:0], 1'b0};
        end
        r.rem = t[DVS_W-1:0];
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] sat_dim(logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] lim;
        lim = WIDE_W'(DIM_LIMIT);
        if (v > lim) begin
            return DIM_LIMIT;
        end else if (v < -lim) begin
            return -DIM_LIMIT;
        end
        return v[DIM_W-1:0];
    endfunction

    function automatic logic [DIM_W-1:0] sat_steps(logic [NUM_W:0] v);
        if (v[NUM_W:DIM_W] != '0) begin
            return {DIM_W{1'b1}};
        end
        return v[DIM_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/line_grid_snap.sv =====
// Baseline grid snapper: top level with APB register file and the full pipeline.
// Depends on lgs_pkg (types, constants, division step and saturation helpers).
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+------------------------------------
//  s (line)  | in        | s_tvalid/s_tready    | current_height, current_depth
//  m (snap)  | out       | m_tvalid/m_tready    | heights/depths/steps, tuser=stepped
//  apb       | in/out    | psel/penable/pready  | eight configuration registers
//
// One line enters per cycle while the output is not stalled. Each of the two
// 33-stage restoring dividers turns the pitch loops into a ceiling division,
// one quotient bit per stage. The whole pipeline advances together whenever
// the output register is empty or being drained, so a stall on the output
// holds every stage in place. Reset is synchronous and active low; it clears
// the configuration registers and all valid bits, while payload registers
// are not reset.
module line_grid_snap (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lgs_pkg::ADDR_W-1:0]    paddr,
    input  logic [lgs_pkg::DATA_W-1:0]    pwdata,
    output logic [lgs_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // line input: [30:0] current_height, [61:31] current_depth, [63:62] zero
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lgs_pkg::IN_W-1:0]      s_tdata,
    // result: [30:0] new_height, [61:31] new_depth, [92:62] height_steps,
    //         [123:93] depth_steps, [127:124] zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lgs_pkg::OUT_W-1:0]     m_tdata,
    // result tuser: [0] stepped
    output logic                          m_tuser
);
    import lgs_pkg::*;

    localparam int NB = NUM_W;

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while the pipeline
    // is empty (the block does not enforce this), so every stage may read them directly.
    // ------------------------------------------------------------------
    logic                     r_snap_en;
    logic signed [DIM_W-1:0]  r_lh, r_ld, r_htol, r_dtol, r_ctol;
    logic [1:0]               r_step, r_pin;
    logic [DVS_W-1:0]         r_inc;
    logic                     wr_en;
    logic [DVS_W-1:0]         ln;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_en <= 1'b0;
            r_lh      <= '0;
            r_ld      <= '0;
            r_htol    <= '0;
            r_dtol    <= '0;
            r_ctol    <= '0;
            r_step    <= '0;
            r_pin     <= '0;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_SNAP_EN: r_snap_en <= pwdata[0];
                REG_LINE_HT: r_lh      <= pwdata[DIM_W-1:0];
                REG_LINE_DP: r_ld      <= pwdata[DIM_W-1:0];
                REG_HT_TOL:  r_htol    <= pwdata[DIM_W-1:0];
                REG_DP_TOL:  r_dtol    <= pwdata[DIM_W-1:0];
                REG_COM_TOL: r_ctol    <= pwdata[DIM_W-1:0];
                REG_STEP:    r_step    <= pwdata[1:0];
                REG_PIN:     r_pin     <= pwdata[1:0];
                default:     r_pin     <= r_pin;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_SNAP_EN: prdata = {31'd0, r_snap_en};
            REG_LINE_HT: prdata = {r_lh[DIM_W-1], r_lh};
            REG_LINE_DP: prdata = {r_ld[DIM_W-1], r_ld};
            REG_HT_TOL:  prdata = {r_htol[DIM_W-1], r_htol};
            REG_DP_TOL:  prdata = {r_dtol[DIM_W-1], r_dtol};
            REG_COM_TOL: prdata = {r_ctol[DIM_W-1], r_ctol};
            REG_STEP:    prdata = {30'd0, r_step};
            REG_PIN:     prdata = {30'd0, r_pin};
            default:     prdata = '0;
        endcase
    end

    // The divisor is the full pitch, or half of it in half-pitch mode. It is
    // registered from the configuration so the divider stages see a flop.
    assign ln = DVS_W'(r_lh) + DVS_W'(r_ld);

    always_ff @(posedge i_clk) begin
        r_inc <= (r_step == STEP_HALF) ? {1'b0, ln[DVS_W-1:1]} : ln;
    end

    // ------------------------------------------------------------------
    // Pipeline control: all stages move together.
    // ------------------------------------------------------------------
    logic r_v1, r_vp1, r_vp2, r_vo;
    logic r_vd [0:NB];
    logic adv;

    assign adv      = !r_vo || m_tready;
    assign s_tready = adv;

    // Stage 1: capture the line and subtract the tolerances.
    logic signed [DIM_W-1:0] r_ht1, r_dp1;
    logic signed [NUM_W-1:0] r_th1, r_td1;
    logic signed [DIM_W-1:0] in_ht, in_dp;

    assign in_ht = s_tdata[DIM_W-1:0];
    assign in_dp = s_tdata[2*DIM_W-1:DIM_W];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ht1 <= in_ht;
            r_dp1 <= in_dp;
            r_th1 <= NUM_W'(in_ht) - NUM_W'(r_htol) - NUM_W'(r_ctol);
            r_td1 <= NUM_W'(in_dp) - NUM_W'(r_dtol) - NUM_W'(r_ctol);
        end
    end

    // Stage 2: raise short sides to the grid line, detect the oversize case
    // and form the ceiling-division dividends (zero when no step is needed).
    logic                    en, less_h, less_d, ov2;
    logic signed [NUM_W-1:0] lh33, ld33;
    logic signed [DIM_W-1:0] hv2, dv2;
    logic signed [NUM_W+1:0] dif_h, dif_d;
    logic [NUM_W-1:0]        num_h, num_d;

    always_comb begin
        lh33   = NUM_W'(r_lh);
        ld33   = NUM_W'(r_ld);
        en     = r_snap_en && (r_lh > 0) && (r_ld > 0);
        less_h = r_th1 < lh33;
        less_d = r_td1 < ld33;
        hv2    = (en && less_h) ? r_lh : r_ht1;
        dv2    = (en && less_d) ? r_ld : r_dp1;
        ov2    = en && ((hv2 > r_lh) || (dv2 > r_ld));
        dif_h  = (NUM_W+2)'(r_th1) - (NUM_W+2)'(lh33) + (NUM_W+2)'(r_inc) - 1;
        dif_d  = (NUM_W+2)'(r_td1) - (NUM_W+2)'(ld33) + (NUM_W+2)'(r_inc) - 1;
        num_h  = (r_th1 > lh33) ? dif_h[NUM_W-1:0] : '0;
        num_d  = (r_td1 > ld33) ? dif_d[NUM_W-1:0] : '0;
    end

    // Divider stages: index 0 is loaded, each later index resolves one bit.
    t_div                    r_dh  [0:NB];
    t_div                    r_dd  [0:NB];
    logic [NUM_W-1:0]        r_nh  [0:NB];
    logic [NUM_W-1:0]        r_nd  [0:NB];
    logic signed [DIM_W-1:0] r_hv  [0:NB];
    logic signed [DIM_W-1:0] r_dv  [0:NB];
    logic                    r_ov  [0:NB];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dh[0] <= '{rem: '0, nsh: num_h, quo: '0};
            r_dd[0] <= '{rem: '0, nsh: num_d, quo: '0};
            r_nh[0] <= num_h;
            r_nd[0] <= num_d;
            r_hv[0] <= hv2;
            r_dv[0] <= dv2;
            r_ov[0] <= ov2;
            for (int k = 1; k <= NB; k++) begin
                r_dh[k] <= div_step(r_dh[k-1], r_inc);
                r_dd[k] <= div_step(r_dd[k-1], r_inc);
                r_nh[k] <= r_nh[k-1];
                r_nd[k] <= r_nd[k-1];
                r_hv[k] <= r_hv[k-1];
                r_dv[k] <= r_dv[k-1];
                r_ov[k] <= r_ov[k-1];
            end
        end
    end

    // Post stage 1: the multiple of the step is dividend minus remainder, so
    // no multiplier is needed. Half-pitch mode evens out an odd step total by
    // giving one more step to the side that has fewer (depth on a tie).
    logic [NUM_W:0]          q_h, q_d;
    logic [NUM_W+1:0]        p_h, p_d;
    logic [NUM_W:0]          r_qh, r_qd;
    logic [NUM_W+1:0]        r_ph, r_pd;
    logic signed [DIM_W-1:0] r_hvp1, r_dvp1;
    logic                    r_ovp1;

    always_comb begin
        q_h = {1'b0, r_dh[NB].quo};
        q_d = {1'b0, r_dd[NB].quo};
        p_h = (NUM_W+2)'(r_nh[NB]) - (NUM_W+2)'(r_dh[NB].rem);
        p_d = (NUM_W+2)'(r_nd[NB]) - (NUM_W+2)'(r_dd[NB].rem);
        if (r_step == STEP_HALF && (q_h[0] ^ q_d[0])) begin
            if (q_h < q_d) begin
                q_h = q_h + 1'b1;
                p_h = p_h + (NUM_W+2)'(r_inc);
            end else begin
                q_d = q_d + 1'b1;
                p_d = p_d + (NUM_W+2)'(r_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_qh   <= q_h;
            r_qd   <= q_d;
            r_ph   <= p_h;
            r_pd   <= p_d;
            r_hvp1 <= r_hv[NB];
            r_dvp1 <= r_dv[NB];
            r_ovp1 <= r_ov[NB];
        end
    end

    // Post stage 2: grow each side by its steps, plus the step count itself
    // when the pitch is odd in half-pitch mode; keep mode leaves the values.
    logic signed [WIDE_W-1:0] nht2, ndp2;
    logic [NUM_W:0]           st_h2, st_d2;
    logic                     odd;
    logic signed [WIDE_W-1:0] r_nht, r_ndp;
    logic [NUM_W:0]           r_sth, r_std;
    logic                     r_ovp2;

    always_comb begin
        odd   = r_lh[0] ^ r_ld[0];
        nht2  = WIDE_W'(r_hvp1);
        ndp2  = WIDE_W'(r_dvp1);
        st_h2 = '0;
        st_d2 = '0;
        if (r_ovp1) begin
            case (r_step)
                STEP_WHOLE: begin
                    nht2  = WIDE_W'(r_lh) + WIDE_W'(r_ph);
                    ndp2  = WIDE_W'(r_ld) + WIDE_W'(r_pd);
                    st_h2 = r_qh;
                    st_d2 = r_qd;
                end
                STEP_HALF: begin
                    nht2  = WIDE_W'(r_lh) + WIDE_W'(r_ph)
                          + (odd ? WIDE_W'(r_qh) : WIDE_W'(0));
                    ndp2  = WIDE_W'(r_ld) + WIDE_W'(r_pd)
                          + (odd ? WIDE_W'(r_qd) : WIDE_W'(0));
                    st_h2 = r_qh;
                    st_d2 = r_qd;
                end
                default: begin
                    nht2 = WIDE_W'(r_hvp1);
                    ndp2 = WIDE_W'(r_dvp1);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_nht  <= nht2;
            r_ndp  <= ndp2;
            r_sth  <= st_h2;
            r_std  <= st_d2;
            r_ovp2 <= r_ovp1;
        end
    end

    // Output stage: pin to top or bottom, then saturate into the output register.
    logic signed [WIDE_W-1:0] fh, fd;
    logic [OUT_W-1:0]         r_out;
    logic                     r_stepped;

    always_comb begin
        fh = r_nht;
        fd = r_ndp;
        if (r_ovp2 && r_pin[0]) begin
            fd = r_ndp + r_nht - WIDE_W'(r_lh);
            fh = WIDE_W'(r_lh);
        end else if (r_ovp2 && r_pin[1]) begin
            fh = r_nht + r_ndp - WIDE_W'(r_ld);
            fd = WIDE_W'(r_ld);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out     <= {4'd0, sat_steps(r_std), sat_steps(r_sth),
                          sat_dim(fd), sat_dim(fh)};
            r_stepped <= r_ovp2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_vp1 <= 1'b0;
            r_vp2 <= 1'b0;
            r_vo  <= 1'b0;
            for (int k = 0; k <= NB; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else if (adv) begin
            r_v1    <= s_tvalid;
            r_vd[0] <= r_v1;
            for (int k = 1; k <= NB; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
            r_vp1 <= r_vd[NB];
            r_vp2 <= r_vp1;
            r_vo  <= r_vp2;
        end
    end

    assign m_tvalid = r_vo;
    assign m_tdata  = r_out;
    assign m_tuser  = r_stepped;

endmodule

// ===== hw/rtl/lgs_check.sv =====
// Port-level checker for the baseline grid snapper, bound to line_grid_snap.
// Depends on lgs_pkg for field widths.
module lgs_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          pready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [lgs_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          m_tuser
);
    import lgs_pkg::*;

    // A held result keeps its data until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Step counts are only nonzero on the oversize path.
    a_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser |-> m_tdata[123:62] == '0)
        else $error("steps reported without stepping");

    // Saturation never lets the most negative code through.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[30:0] != 31'h40000000 && m_tdata[61:31] != 31'h40000000)
        else $error("dimension outside limit");

    // The configuration port never waits.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind line_grid_snap lgs_check u_lgs_check (.*);
